// ----- design/drf_pkg.sv -----
`default_nettype none

package drf_pkg;

    localparam int ActionWidth = 2;
    localparam int WordWidth   = 64;
    localparam int ExpWidth    = 11;
    localparam int MantWidth   = 52;

    typedef logic [ActionWidth-1:0] action_t;
    typedef logic [WordWidth-1:0]   word_t;
    typedef logic [ExpWidth-1:0]    exp_t;
    typedef logic [MantWidth-1:0]   mant_t;

    localparam action_t ACT_SPLIT = 2'd0;
    localparam action_t ACT_FLOOR = 2'd1;
    localparam action_t ACT_CEIL  = 2'd2;

    localparam exp_t  EXP_SPECIAL = 11'h7FF;
    localparam exp_t  EXP_BIAS    = 11'd1023;
    localparam exp_t  EXP_ALL_INT = 11'd1075;
    localparam word_t QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam word_t DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

endpackage

`default_nettype wire

// ----- design/drf_operand_if.sv -----
`default_nettype none

interface drf_operand_if
    import drf_pkg::*;
();
    logic    valid;
    logic    ready;
    action_t action;
    word_t   value_bits;

    modport source (output valid, action, value_bits, input ready);
    modport sink   (input valid, action, value_bits, output ready);
endinterface

`default_nettype wire

// ----- design/drf_result_if.sv -----
`default_nettype none

interface drf_result_if
    import drf_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t integer_part;
    word_t fraction_part;

    modport source (output valid, integer_part, fraction_part, input ready);
    modport sink   (input valid, integer_part, fraction_part, output ready);
endinterface

`default_nettype wire

// ----- design/double_round_and_fraction_split.sv -----
// Channel   Direction  Payload
// operand   in         action (2), value_bits (64)
// result    out        integer_part (64), fraction_part (64)
//
// A request is registered on entry, computed in one pass and registered again on exit.
// One request is accepted per cycle while the entry register is empty or can pass its content on.
// Reset (rst_n low) empties both registers at once.
// A stalled result holds its register, and the entry register keeps accepting while
// the exit register can take its content.
`default_nettype none

module double_round_and_fraction_split
    import drf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    drf_operand_if.sink   operand,
    drf_result_if.source  result
);

    logic    in_valid_reg;
    action_t act_reg;
    word_t   x_reg;
    logic    out_valid_reg;
    word_t   ip_reg;
    word_t   fp_reg;

    logic out_free;
    logic in_free;

    assign out_free       = !out_valid_reg || result.ready;
    assign in_free        = !in_valid_reg || out_free;
    assign operand.ready  = in_free;

    exp_t  e;
    logic  neg;
    logic  lo;
    logic  hi;
    logic [5:0] k;
    word_t mask;
    word_t t;
    logic  is_int;
    logic  up;
    word_t r;
    word_t rounded;
    mant_t frac;
    logic [5:0] p;
    logic [5:0] sh;
    mant_t norm;
    word_t split_fp;
    logic  is_rnd;
    word_t ip_next;
    word_t fp_next;

    always_comb
    begin
        e      = x_reg[62:52];
        neg    = x_reg[63];
        lo     = e < EXP_BIAS;
        hi     = e >= EXP_ALL_INT;
        k      = 6'(EXP_ALL_INT - e);
        mask   = (64'd1 << k) - 64'd1;
        if (lo)
        begin
            t      = {neg, 63'd0};
            is_int = x_reg[62:0] == 63'd0;
        end
        else if (hi)
        begin
            t      = x_reg;
            is_int = 1'b1;
        end
        else
        begin
            t      = x_reg & ~mask;
            is_int = (x_reg & mask) == 64'd0;
        end

        is_rnd = (act_reg == ACT_FLOOR) || (act_reg == ACT_CEIL);
        up     = !is_int && (((act_reg == ACT_FLOOR) && neg) ||
                             ((act_reg == ACT_CEIL) && !neg));
        if (!up)
            r = t;
        else if (lo)
            r = {neg, EXP_BIAS, 52'd0};
        else
            r = t + mask + 64'd1;
        rounded = (r[62:0] == 63'd0) ? 64'd0 : r;

        frac = x_reg[51:0] & mask[51:0];
        p    = 6'd0;
        for (int i = 0; i < MantWidth; i++)
        begin
            if (frac[i])
                p = 6'(i);
        end
        sh   = 6'd51 - p;
        norm = frac << sh;
        if (is_int)
            split_fp = 64'd0;
        else if (lo)
            split_fp = x_reg;
        else
            split_fp = {neg, exp_t'(e - 11'd1 - {5'd0, sh}), norm[50:0], 1'b0};

        if (e == EXP_SPECIAL)
        begin
            ip_next = x_reg;
            if (is_rnd)
                fp_next = 64'd0;
            else if (x_reg[51:0] != 52'd0)
                fp_next = x_reg | QUIET_BIT;
            else
                fp_next = DEFAULT_NAN;
        end
        else if (is_rnd)
        begin
            ip_next = rounded;
            fp_next = 64'd0;
        end
        else
        begin
            ip_next = t;
            fp_next = split_fp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
                in_valid_reg <= operand.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && operand.valid)
        begin
            act_reg <= operand.action;
            x_reg   <= operand.value_bits;
        end
        if (out_free && in_valid_reg)
        begin
            ip_reg <= ip_next;
            fp_reg <= fp_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.integer_part  = ip_reg;
    assign result.fraction_part = fp_reg;

    // A request that leaves the entry register always lands in the exit register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_free |=> out_valid_reg)
        else $error("request lost between entry and exit registers");

    // A held request in the entry register keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(x_reg) && $stable(act_reg))
        else $error("entry register overwritten while blocked");

    // A NaN fraction only comes from a NaN or infinite operand.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (fp_reg[62:52] == EXP_SPECIAL) |-> ip_reg[62:52] == EXP_SPECIAL)
        else $error("special fraction from a finite operand");

endmodule

`default_nettype wire
